// ===== rtl/core/byte_ring_buffer_fifo_core_defines.svh =====
// Assertion macros shared by the byte ring buffer RTL.
`ifndef BYTE_RING_BUFFER_FIFO_CORE_DEFINES_SVH
`define BYTE_RING_BUFFER_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BRBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brbf check failed: same-cycle implication");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BRBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brbf check failed: next-cycle implication");

`endif

// ===== rtl/core/brbf_pkg.sv =====
// Shared widths, command and status codes for the byte ring buffer.
package brbf_pkg;

   // Transaction field widths
   localparam int CMD_W    = 3;
   localparam int DATA_W   = 8;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 2;
   localparam int REPORT_W = 12;
   localparam int CFG_W    = 13;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

   // Defaults
   localparam int DEPTH_DEFAULT     = 4096;
   localparam int MAX_BLOCK_DEFAULT = 64;
   localparam int SIZE_AT_RESET     = 4096;
   localparam int SIZE_MIN          = 2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

   // Result status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

endpackage

// ===== rtl/core/brbf_if.sv =====
// Request and response channel interfaces of the byte ring buffer.
interface brbf_req_if
   import brbf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [DATA_W-1:0] data;
   logic              first;
   logic [LEN_W-1:0]  length;

   modport source (output valid, cmd, data, first, length, input ready);
   modport sink   (input valid, cmd, data, first, length, output ready);
endinterface

interface brbf_rsp_if
   import brbf_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data_res;
   logic                data_valid;
   logic                last;
   logic [STATUS_W-1:0] status;
   logic [REPORT_W-1:0] use_size;
   logic [REPORT_W-1:0] free_size;

   modport source (output valid, data_res, data_valid, last, status, use_size, free_size,
                   input ready);
   modport sink   (input valid, data_res, data_valid, last, status, use_size, free_size,
                   output ready);
endinterface

// ===== rtl/core/byte_ring_buffer_fifo_core.sv =====
// Byte ring buffer that keeps one slot empty, with block enqueue and dequeue/peek.
//
// The bytes live in one DEPTH x 8 synchronous memory (one write port, one read
// port with a registered read); indices, the used count and block tracking are
// flip-flops, and results leave through a one-entry output register. Enqueue
// bytes, clear, size queries and every single-status transaction can be accepted
// back to back while the previous result is being taken. A dequeue or peek of N
// bytes holds off new requests until its last byte enters the output register
// and streams one byte per cycle while the output is taken, limited by the single
// memory read port: one read is issued per cycle and its registered data is
// forwarded into the output register when free. A write to buffer_size empties
// the ring; its value is held to the range 2..DEPTH and reads back as held. No
// clearing pass is needed after reset: only bytes that were written are ever read.
`include "byte_ring_buffer_fifo_core_defines.svh"

module byte_ring_buffer_fifo_core
   import brbf_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   brbf_req_if.sink              req_if,
   brbf_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RESET_SIZE_I = (SIZE_AT_RESET > DEPTH) ? DEPTH :
                                 ((SIZE_AT_RESET < SIZE_MIN) ? SIZE_MIN : SIZE_AT_RESET);
   localparam logic [CNT_W-1:0] RESET_SIZE = CNT_W'(RESET_SIZE_I);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   // Byte store
   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_we;
   logic              rd_en;

   // Ring state
   logic [CNT_W-1:0]  size_ff, size_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  used_ff, used_in;
   logic              blk_acc_ff, blk_acc_in;
   logic [LEN_W-1:0]  blk_rem_ff, blk_rem_in;

   // Read burst
   logic              state_ff, state_in;
   logic [PTR_W-1:0]  burst_ptr_ff, burst_ptr_in;
   logic [LEN_W-1:0]  burst_cnt_ff, burst_cnt_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_dvalid_ff, rsp_dvalid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [REPORT_W-1:0] rsp_use_ff, rsp_use_in;
   logic [REPORT_W-1:0] rsp_free_ff, rsp_free_in;

   // Handshake and helpers
   logic             out_free;
   logic             req_rdy;
   logic             req_fire;
   logic             pend_move;
   logic             csr_wr;
   logic [LEN_W-1:0] len_c;
   logic [CNT_W-1:0] free_cur;
   logic [PTR_W-1:0] wr_ptr_inc;
   logic [PTR_W-1:0] burst_ptr_inc;
   logic [PTR_W-1:0] rd_ptr_adv;
   logic [31:0]      rd_sum;
   logic [31:0]      cfg_raw;
   logic [CNT_W-1:0] cfg_held;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_rdy   = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_if.valid && req_rdy;
   assign pend_move = pend_ff && out_free;
   assign rd_en     = (state_ff == ST_READ) && (burst_cnt_ff != '0) && (!pend_ff || out_free);
   assign req_if.ready = req_rdy;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_BUFFER_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BUFFER_SIZE) ? CSR_DATA_W'(size_ff) : '0;

   // Hold the written size to 2..DEPTH
   assign cfg_raw  = 32'(csr_pwdata[CFG_W-1:0]);
   assign cfg_held = (cfg_raw < 32'(SIZE_MIN)) ? CNT_W'(SIZE_MIN) :
                     ((cfg_raw > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cfg_raw));

   // Length held to the largest block
   assign len_c = (32'(req_if.length) > 32'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : req_if.length;

   assign free_cur = size_ff - CNT_W'(1) - CNT_W'(used_ff);

   // Index wrap at the configured size
   assign wr_ptr_inc    = ((CNT_W'(wr_ptr_ff) + CNT_W'(1)) == size_ff) ? '0 :
                          PTR_W'(wr_ptr_ff + PTR_W'(1));
   assign burst_ptr_inc = ((CNT_W'(burst_ptr_ff) + CNT_W'(1)) == size_ff) ? '0 :
                          PTR_W'(burst_ptr_ff + PTR_W'(1));
   assign rd_sum        = 32'(rd_ptr_ff) + 32'(len_c);
   assign rd_ptr_adv    = (rd_sum >= 32'(size_ff)) ? PTR_W'(rd_sum - 32'(size_ff)) :
                          PTR_W'(rd_sum);

   // Next-state logic
   always_comb begin
      logic [LEN_W-1:0]    len0;
      logic                do_wr;
      logic                single;
      logic [STATUS_W-1:0] st;
      logic [CNT_W-1:0]    free_next;

      len0          = '0;
      do_wr         = 1'b0;
      single        = 1'b0;
      st            = STATUS_OK;
      free_next     = '0;
      mem_we        = 1'b0;
      size_in       = size_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      used_in       = used_ff;
      blk_acc_in    = blk_acc_ff;
      blk_rem_in    = blk_rem_ff;
      state_in      = state_ff;
      burst_ptr_in  = burst_ptr_ff;
      burst_cnt_in  = burst_cnt_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_dvalid_in = rsp_dvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_use_in    = rsp_use_ff;
      rsp_free_in   = rsp_free_ff;

      // Accepted request transaction
      if (req_fire) begin
         single = 1'b1;
         unique case (req_if.cmd)
            CMD_ENQUEUE: begin
               if (req_if.first) begin
                  len0       = (len_c == '0) ? LEN_W'(1) : len_c;
                  blk_rem_in = len0 - LEN_W'(1);
                  if (32'(free_cur) >= 32'(len0)) begin
                     blk_acc_in = 1'b1;
                     do_wr      = 1'b1;
                  end else begin
                     blk_acc_in = 1'b0;
                     st         = STATUS_FULL;
                  end
               end else if (blk_rem_ff != '0) begin
                  blk_rem_in = blk_rem_ff - LEN_W'(1);
                  if (blk_acc_ff) begin
                     do_wr = 1'b1;
                  end else begin
                     st = STATUS_FULL;
                  end
               end
               if (do_wr && (free_cur != '0)) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_ptr_inc;
                  used_in   = used_ff + PTR_W'(1);
               end
               if (blk_rem_in == '0) begin
                  blk_acc_in = 1'b0;
               end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
               if (32'(used_ff) < 32'(len_c)) begin
                  st = STATUS_SHORT;
               end else if (len_c != '0) begin
                  single       = 1'b0;
                  state_in     = ST_READ;
                  burst_ptr_in = rd_ptr_ff;
                  burst_cnt_in = len_c;
                  if (req_if.cmd == CMD_DEQUEUE) begin
                     rd_ptr_in = rd_ptr_adv;
                     used_in   = used_ff - PTR_W'(len_c);
                  end
               end
            end
            CMD_CLEAR: begin
               wr_ptr_in  = '0;
               rd_ptr_in  = '0;
               used_in    = '0;
               blk_acc_in = 1'b0;
               blk_rem_in = '0;
            end
            default: begin
               // Size query; unknown codes act the same
            end
         endcase
      end

      // Single-result transactions go straight to the output register
      if (single) begin
         free_next     = size_ff - CNT_W'(1) - CNT_W'(used_in);
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_dvalid_in = 1'b0;
         rsp_last_in   = 1'b1;
         rsp_status_in = st;
         rsp_use_in    = REPORT_W'(32'(used_in));
         rsp_free_in   = REPORT_W'(32'(free_next));
      end

      // Read burst: forward the registered read data, issue the next read
      if (pend_move) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = rd_data_ff;
         rsp_dvalid_in = 1'b1;
         rsp_last_in   = pend_last_ff;
         rsp_status_in = STATUS_OK;
         rsp_use_in    = REPORT_W'(32'(used_ff));
         rsp_free_in   = REPORT_W'(32'(free_cur));
         pend_in       = 1'b0;
         if (pend_last_ff) begin
            state_in = ST_IDLE;
         end
      end
      if (rd_en) begin
         burst_ptr_in = burst_ptr_inc;
         burst_cnt_in = burst_cnt_ff - LEN_W'(1);
         pend_in      = 1'b1;
         pend_last_in = (burst_cnt_ff == LEN_W'(1));
      end

      // Size write empties the ring
      if (csr_wr) begin
         size_in    = cfg_held;
         wr_ptr_in  = '0;
         rd_ptr_in  = '0;
         used_in    = '0;
         blk_acc_in = 1'b0;
         blk_rem_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= RESET_SIZE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         used_ff      <= '0;
         blk_acc_ff   <= 1'b0;
         blk_rem_ff   <= '0;
         state_ff     <= ST_IDLE;
         burst_cnt_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         used_ff      <= used_in;
         blk_acc_ff   <= blk_acc_in;
         blk_rem_ff   <= blk_rem_in;
         state_ff     <= state_in;
         burst_cnt_ff <= burst_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      burst_ptr_ff  <= burst_ptr_in;
      pend_last_ff  <= pend_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_use_ff    <= rsp_use_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_ptr_ff] <= req_if.data;
      end
   end

   // Memory read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[burst_ptr_ff];
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.data_res   = rsp_data_ff;
   assign rsp_if.data_valid = rsp_dvalid_ff;
   assign rsp_if.last       = rsp_last_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.use_size   = rsp_use_ff;
   assign rsp_if.free_size  = rsp_free_ff;

   // Checks
   `BRBF_ASSERT_NOW(a_used_below_size, clock, reset, 1'b1, (CNT_W'(used_ff) < size_ff))
   `BRBF_ASSERT_NOW(a_ptrs_in_ring, clock, reset, 1'b1,
                    (CNT_W'(wr_ptr_ff) < size_ff) && (CNT_W'(rd_ptr_ff) < size_ff))
   `BRBF_ASSERT_NEXT(a_read_lands, clock, reset, rd_en, pend_ff && (state_ff == ST_READ))
   `BRBF_ASSERT_NOW(a_idle_no_burst, clock, reset, state_ff == ST_IDLE,
                    !pend_ff && (burst_cnt_ff == '0))

endmodule
